FILE: rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types for the max-heap priority queue: request and status codes,
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic ins_start;
    logic full_reject;
    logic empty_reject;
    logic rm_start;
    logic rm_last;
    logic up_rd;
    logic up_step;
    logic dn_rd;
    logic dn_step;
    logic wr_val;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_root;
    logic up_gt;
    logic leaf;
    logic dn_gt;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/mhpq_ram.sv
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ram #(
  parameter int Width = 32,
  parameter int Depth = 128,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [Width-1:0] rdata_a_o,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

FILE: rtl/mhpq_dp.sv
// ----------------------------------------------------------------------------
// mhpq_dp
// Heap datapath: entry count, walk position, carried value, root copy,
// result registers and the heap RAM with its compare logic.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_dp
  import mhpq_pkg::*;
#(
  parameter int Capacity = 128,
  localparam int AddrW = $clog2(Capacity),
  localparam int CntW = $clog2(Capacity + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  input  wire logic signed [31:0] value_i,
  output dp_stat_t                stat_o,
  output logic             [1:0]  status_o,
  output logic signed      [31:0] removed_value_o,
  output logic             [7:0]  item_count_o,
  output logic signed      [31:0] top_value_o
);

  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    pos_q, pos_d;
  logic signed [31:0] val_q, val_d;
  logic signed [31:0] top_q, top_d;
  logic signed [31:0] rem_q, rem_d;
  status_e            status_q, status_d;

  logic               we;
  logic signed [31:0] wdata;
  logic [AddrW-1:0]   raddr_a, raddr_b;
  logic signed [31:0] rd_a, rd_b;

  logic [CntW:0]      left_idx, right_idx;
  logic [CntW-1:0]    parent_idx;
  logic               r_valid, r_sel;
  logic signed [31:0] cand;
  logic [CntW:0]      cand_idx;

  assign parent_idx = pos_q >> 1;
  assign left_idx   = {pos_q, 1'b0};
  assign right_idx  = {pos_q, 1'b1};
  assign r_valid    = right_idx <= {1'b0, count_q};
  assign r_sel      = r_valid && (rd_b > rd_a);
  assign cand       = r_sel ? rd_b : rd_a;
  assign cand_idx   = r_sel ? right_idx : left_idx;

  always_comb begin
    raddr_a = AddrW'(left_idx - 1'b1);
    if (cmd_i.up_rd) begin
      raddr_a = AddrW'(parent_idx - 1'b1);
    end else if (cmd_i.rm_start) begin
      raddr_a = AddrW'(count_q - 1'b1);
    end else if (cmd_i.dn_rd) begin
      raddr_a = AddrW'(left_idx - 1'b1);
    end
  end
  assign raddr_b = AddrW'(left_idx);

  assign we    = cmd_i.wr_val | cmd_i.up_step | cmd_i.dn_step;
  assign wdata = cmd_i.up_step ? rd_a : (cmd_i.dn_step ? cand : val_q);

  mhpq_ram #(
    .Width (32),
    .Depth (Capacity)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (AddrW'(pos_q - 1'b1)),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_comb begin
    count_d  = count_q;
    pos_d    = pos_q;
    val_d    = val_q;
    top_d    = top_q;
    rem_d    = rem_q;
    status_d = status_q;
    if (cmd_i.ins_start) begin
      count_d  = count_q + 1'b1;
      pos_d    = count_q + 1'b1;
      val_d    = value_i;
      rem_d    = '0;
      status_d = STAT_OK;
    end
    if (cmd_i.full_reject) begin
      rem_d    = '0;
      status_d = STAT_FULL;
    end
    if (cmd_i.empty_reject) begin
      rem_d    = '0;
      status_d = STAT_EMPTY;
    end
    if (cmd_i.rm_start) begin
      count_d  = count_q - 1'b1;
      rem_d    = top_q;
      status_d = STAT_OK;
    end
    if (cmd_i.rm_last) begin
      val_d = rd_a;
      pos_d = CntW'(1);
    end
    if (cmd_i.up_step) begin
      pos_d = parent_idx;
    end
    if (cmd_i.dn_step) begin
      pos_d = CntW'(cand_idx);
    end
    // keep a copy of the root so the top is visible without a read
    if (we && pos_q == CntW'(1)) begin
      top_d = wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= STAT_OK;
    end else begin
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    val_q <= val_d;
    top_q <= top_d;
    rem_q <= rem_d;
  end

  assign stat_o.full     = count_q == CntW'(Capacity);
  assign stat_o.empty    = count_q == '0;
  assign stat_o.pos_root = pos_q == CntW'(1);
  assign stat_o.up_gt    = val_q > rd_a;
  assign stat_o.leaf     = left_idx > {1'b0, count_q};
  assign stat_o.dn_gt    = cand > val_q;

  assign status_o        = status_q;
  assign removed_value_o = rem_q;
  assign item_count_o    = 8'(count_q);
  assign top_value_o     = (count_q != '0) ? top_q : '0;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count above capacity");

  a_insert_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_start |=> count_q == CntW'($past(count_q) + 1'b1))
    else $error("insert did not grow the count by one");

  a_remove_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rm_start |=> count_q == CntW'($past(count_q) - 1'b1))
    else $error("removal did not shrink the count by one");

endmodule

`default_nettype wire

FILE: rtl/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Request sequencer: accepts a request, drives the sift-up or sift-down
// walk one heap level at a time and strobes the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ctrl
  import mhpq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire logic     req_type_i,
  input  wire dp_stat_t stat_i,
  output logic          busy,
  output logic          result_valid_o,
  output cmd_t          cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_RM_LAST,
    S_DN_RD,
    S_DN_CMP,
    S_RESP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (req_type_i == REQ_INSERT) begin
            if (stat_i.full) begin
              cmd_o.full_reject = 1'b1;
              state_d           = S_RESP;
            end else begin
              cmd_o.ins_start = 1'b1;
              state_d         = S_UP_RD;
            end
          end else begin
            if (stat_i.empty) begin
              cmd_o.empty_reject = 1'b1;
              state_d            = S_RESP;
            end else begin
              cmd_o.rm_start = 1'b1;
              state_d        = S_RM_LAST;
            end
          end
        end
      end
      S_UP_RD: begin
        if (stat_i.pos_root) begin
          cmd_o.wr_val = 1'b1;
          state_d      = S_RESP;
        end else begin
          cmd_o.up_rd = 1'b1;
          state_d     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat_i.up_gt) begin
          cmd_o.up_step = 1'b1;
          state_d       = S_UP_RD;
        end else begin
          cmd_o.wr_val = 1'b1;
          state_d      = S_RESP;
        end
      end
      S_RM_LAST: begin
        cmd_o.rm_last = 1'b1;
        // last entry was the root itself: nothing left to place
        state_d = stat_i.empty ? S_RESP : S_DN_RD;
      end
      S_DN_RD: begin
        if (stat_i.leaf) begin
          cmd_o.wr_val = 1'b1;
          state_d      = S_RESP;
        end else begin
          cmd_o.dn_rd = 1'b1;
          state_d     = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (stat_i.dn_gt) begin
          cmd_o.dn_step = 1'b1;
          state_d       = S_DN_RD;
        end else begin
          cmd_o.wr_val = 1'b1;
          state_d      = S_RESP;
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy           = state_q != S_IDLE;
  assign result_valid_o = state_q == S_RESP;

  a_one_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.ins_start, cmd_o.full_reject, cmd_o.empty_reject, cmd_o.rm_start}))
    else $error("more than one request start command");

  a_one_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.wr_val, cmd_o.up_step, cmd_o.dn_step}))
    else $error("conflicting heap writes");

  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o && !busy)
    else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

FILE: rtl/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed 32-bit values with insert and remove-maximum.
// ----------------------------------------------------------------------------
// A request (req_type_i: insert or remove maximum, value_i) transfers at a
// rising edge with start high and busy low. busy stays high until the
// request is finished; one request is worked on at a time.
// Each request gives one result, shown for exactly one cycle with
// result_valid_o high: status_o, removed_value_o, item_count_o and
// top_value_o (root after the request, zero when empty). The receiver
// cannot stall; the result must be taken in that cycle.
// Each heap level of the walk takes one RAM read, then a compare and
// write. An insert climbs until a compare stops it or it reaches the
// root; a removal moves the last entry to the root and sinks it until
// it reaches a leaf or a compare stops it; it places nothing when it
// takes the only entry. busy drops in the cycle after the strobe, and
// the next request can transfer from then on. Rejected requests (insert
// into a full heap, removal from an empty one) strobe in the cycle after
// the transfer.
// Reset empties the heap; heap RAM contents are not cleared, only entries
// up to the count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               req_type_i,
  input  wire logic signed [31:0] value_i,
  output logic                    result_valid_o,
  output logic             [1:0]  status_o,
  output logic signed      [31:0] removed_value_o,
  output logic             [7:0]  item_count_o,
  output logic signed      [31:0] top_value_o
);

  cmd_t     cmd;
  dp_stat_t stat;

  mhpq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .req_type_i     (req_type_i),
    .stat_i         (stat),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd)
  );

  mhpq_dp #(
    .Capacity (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .value_i         (value_i),
    .stat_o          (stat),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .item_count_o    (item_count_o),
    .top_value_o     (top_value_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb_max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_max_heap_priority_queue
// Self-checking bench for the max-heap priority queue. A driver pulls
// requests from a pending queue and a monitor checks every result strobe
// against a software heap that is updated on each accepted transfer.
// Stimulus mixes a directed opening with random fill, drain and mixed runs,
// under several idle patterns on the request side.
// ----------------------------------------------------------------------------
module tb_max_heap_priority_queue;
  import mhpq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_DEPTH = 128;
  localparam int RANDOM_ITEMS = 1250;
  localparam int TAIL_CYCLES = 25;

  typedef struct {
    logic              kind;
    logic signed [31:0] value;
    int unsigned        idle_pct;
  } request_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] removed;
    logic [7:0]         count;
    logic signed [31:0] top;
  } heap_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               req_type = REQ_INSERT;
  logic signed [31:0] value = '0;
  logic               result_valid_o;
  logic [1:0]         status_o;
  logic signed [31:0] removed_value_o;
  logic [7:0]         item_count_o;
  logic signed [31:0] top_value_o;

  request_t     pending_requests[$];
  heap_result_t awaited_results[$];

  // software copy of the heap
  logic signed [31:0] heap_slots [1:HEAP_DEPTH];
  int                 heap_count = 0;

  int mismatch_count = 0;
  int gen_count = 0;

  max_heap_priority_queue #(.CAPACITY(HEAP_DEPTH)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type),
    .value_i        (value),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .item_count_o   (item_count_o),
    .top_value_o    (top_value_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic heap_result_t apply_request(logic kind, logic signed [31:0] val);
    heap_result_t       res;
    int                 pos;
    int                 par;
    int                 best;
    logic signed [31:0] tmp;
    res.status  = STAT_OK;
    res.removed = '0;
    if (kind == REQ_INSERT) begin
      if (heap_count >= HEAP_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        heap_count++;
        heap_slots[heap_count] = val;
        pos = heap_count;
        while (pos > 1) begin
          par = pos / 2;
          if (!(heap_slots[pos] > heap_slots[par])) break;
          tmp = heap_slots[pos];
          heap_slots[pos] = heap_slots[par];
          heap_slots[par] = tmp;
          pos = par;
        end
      end
    end else begin
      if (heap_count == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        res.removed = heap_slots[1];
        heap_slots[1] = heap_slots[heap_count];
        heap_count--;
        pos = 1;
        forever begin
          best = pos;
          // larger child wins, left child on a tie
          if (2 * pos <= heap_count && heap_slots[2 * pos] > heap_slots[best])
            best = 2 * pos;
          if (2 * pos + 1 <= heap_count && heap_slots[2 * pos + 1] > heap_slots[best])
            best = 2 * pos + 1;
          if (best == pos) break;
          tmp = heap_slots[pos];
          heap_slots[pos] = heap_slots[best];
          heap_slots[best] = tmp;
          pos = best;
        end
      end
    end
    res.count = 8'(heap_count);
    res.top   = (heap_count > 0) ? heap_slots[1] : '0;
    return res;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom;
      3:       return $signed($urandom_range(16)) - 8;
      4:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                        : 32'h8000_0000 + $urandom_range(3);
    endcase
  endfunction

  // queues one request and tracks the entry count it leaves behind
  task automatic add_request(logic kind, logic signed [31:0] val);
    request_t req;
    req.kind     = kind;
    req.value    = val;
    req.idle_pct = 0;
    pending_requests.push_back(req);
    if (kind == REQ_INSERT && gen_count < HEAP_DEPTH) gen_count++;
    if (kind == REQ_REMOVE && gen_count > 0) gen_count--;
  endtask

  // stimulus
  initial begin
    int unsigned phase_idle [4];
    int          total;
    int          extra;
    phase_idle = '{0, 45, 0, 23};

    // directed opening: empty removal, extremes, ties, drain past empty
    add_request(REQ_REMOVE, 32'h1234_5678);
    add_request(REQ_INSERT, 32'sd0);
    add_request(REQ_INSERT, 32'h7fff_ffff);
    add_request(REQ_INSERT, 32'h8000_0000);
    add_request(REQ_INSERT, -32'sd1);
    add_request(REQ_INSERT, 32'sd1);
    add_request(REQ_INSERT, 32'h7fff_ffff);
    add_request(REQ_INSERT, 32'h8000_0000);
    add_request(REQ_INSERT, 32'haaaa_aaaa);
    add_request(REQ_INSERT, 32'h5555_5555);
    repeat (10) add_request(REQ_REMOVE, 32'hffff_ffff);
    repeat (3) add_request(REQ_INSERT, 32'sd7);
    add_request(REQ_REMOVE, 32'sd0);

    total = pending_requests.size() + RANDOM_ITEMS;
    while (pending_requests.size() < total) begin
      case ($urandom_range(0, 3))
        0: begin
          // fill to capacity, then knock on the full heap
          while (gen_count < HEAP_DEPTH) add_request(REQ_INSERT, pick_value());
          extra = $urandom_range(1, 3);
          repeat (extra) add_request(REQ_INSERT, pick_value());
        end
        1: begin
          // drain to empty, then remove from the empty heap
          while (gen_count > 0) add_request(REQ_REMOVE, $urandom);
          extra = $urandom_range(1, 3);
          repeat (extra) add_request(REQ_REMOVE, $urandom);
        end
        2: begin
          repeat (40) begin
            if ($urandom_range(99) < 55) add_request(REQ_INSERT, pick_value());
            else add_request(REQ_REMOVE, $urandom);
          end
        end
        default: begin
          // narrow value range for plenty of equal keys
          repeat (30) begin
            if ($urandom_range(99) < 60)
              add_request(REQ_INSERT, $signed($urandom_range(6)) - 3);
            else
              add_request(REQ_REMOVE, $urandom);
          end
        end
      endcase
    end

    total = pending_requests.size();
    foreach (pending_requests[i]) pending_requests[i].idle_pct = phase_idle[i * 4 / total];
  end

  // reset, then wait for everything to drain
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_requests.size() != 0 || start) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // driver
  always @(posedge clk_i) begin
    request_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      // a transfer completes at this edge when start was high and busy low
      if (start) awaited_results.push_back(apply_request(req_type, value));
      if (pending_requests.size() != 0 &&
          $urandom_range(99) >= pending_requests[0].idle_pct) begin
        nxt = pending_requests.pop_front();
        start    <= 1'b1;
        req_type <= nxt.kind;
        value    <= nxt.value;
      end else begin
        start <= 1'b0;
        value <= $urandom;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    heap_result_t got;
    heap_result_t want;
    if (rst_ni && result_valid_o) begin
      got.status  = status_e'(status_o);
      got.removed = removed_value_o;
      got.count   = item_count_o;
      got.top     = top_value_o;
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d removed %0d count %0d top %0d",
                   got.status, got.removed, got.count, got.top);
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: status %0d/%0d removed %0d/%0d count %0d/%0d top %0d/%0d",
                     want.status, got.status, want.removed, got.removed,
                     want.count, got.count, want.top, got.top);
        end
      end
    end
  end

endmodule
